// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
`default_nettype none

package swm_pkg;

   // Window depth and derived widths
   localparam int WINDOW_MAX = 64;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 7;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [CFG_W-1:0]         cfg_type;

   // Broadcast to every cell of the sorted chain
   typedef struct packed {
      logic       step;    // update the chain this cycle
      logic       remove;  // window full: drop one copy of old
      sample_type key;     // incoming sample
      sample_type old;     // sample leaving the window
   } cell_ctl_type;

   // Passed from a cell to the cell below it
   typedef struct packed {
      sample_type value;
      logic       gt_key;  // value > key
      logic       eq_old;  // occupied and value == old
   } cell_down_type;

   // Passed from a cell to the cell above it
   typedef struct packed {
      sample_type rval;    // value after removal
      logic       gap;     // key goes at or below this cell
   } cell_up_type;

endpackage

`default_nettype wire

// ===== sv/swm_if.sv =====
// Valid/ready channel interfaces for samples, medians and the window size write.
`default_nettype none

interface swm_req_if import swm_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type median;
   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

interface swm_csr_if import swm_pkg::*;;
   logic    valid;
   logic    ready;
   cfg_type window_size;
   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ===== sv/swm_cell.sv =====
// One cell of the sorted chain: holds one window value, removes and inserts by neighbor exchange.
`default_nettype none

module swm_cell import swm_pkg::*; (
   input  wire logic          clock,
   input  wire cell_ctl_type  ctl,
   input  wire logic          occupied,    // cell holds a window value now
   input  wire logic          kept,        // slot still filled after removal
   input  wire cell_down_type from_above,
   output cell_down_type      to_below,
   input  wire cell_up_type   from_below,
   output cell_up_type        to_above,
   output sample_type         value
);

   sample_type value_ff;
   sample_type value_in;
   sample_type r_value;
   logic       eq_old;
   logic       gt_old;
   logic       gt_key;
   logic       is_evict;
   logic       shift;
   logic       r_gt;
   logic       gap;

   // Local compares against the broadcast key and the leaving value
   always_comb begin
      eq_old = occupied && (value_ff == ctl.old);
      gt_old = occupied && (value_ff > ctl.old);
      gt_key = value_ff > ctl.key;
   end

   // Removal: the highest copy of old drops out, everything above moves down
   always_comb begin
      is_evict = ctl.remove && eq_old && !from_above.eq_old;
      shift    = ctl.remove && (gt_old || is_evict);
      r_value  = shift ? from_above.value  : value_ff;
      r_gt     = shift ? from_above.gt_key : gt_key;
      gap      = !kept || r_gt;
   end

   // Insertion: cells above the gap take the lower neighbor, the gap takes key
   always_comb begin
      if (from_below.gap) begin
         value_in = from_below.rval;
      end else if (gap) begin
         value_in = ctl.key;
      end else begin
         value_in = r_value;
      end
   end

   assign to_below = '{value: value_ff, gt_key: gt_key, eq_old: eq_old};
   assign to_above = '{rval: r_value, gap: gap};
   assign value    = value_ff;

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sliding_window_median.sv =====
// Sliding-window median filter: arrival ring memory plus a sorted chain of cells.
// A sample is captured in S_IDLE as the leaving sample is read from the ring; the chain
// updates in S_UPD and, once the window is full, the median is picked in S_RES. The next
// sample is taken back in S_IDLE, later while a previous result still waits on the output.
// Reset (synchronous): window size 1, window empty; ring and cell contents are
// left as they are and never read before being written again.
`default_nettype none

module sliding_window_median import swm_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   swm_req_if.sink     req_chan,
   swm_rsp_if.source   rsp_chan,
   swm_csr_if.sink     csr_chan
);

   typedef enum logic [1:0] {S_IDLE, S_UPD, S_RES} state_type;

   state_type        state_ff, state_in;
   cfg_type          wsize_ff, wsize_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic             res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       key_ff;
   sample_type       old_ff;
   sample_type       median_ff;
   sample_type       ring_mem [WINDOW_MAX];

   logic [CNT_W-1:0] k_eff;
   logic [CNT_W-1:0] n_kept;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] wr_addr;
   logic             full;
   logic             req_take;
   logic             csr_take;
   logic             load_out;
   cell_ctl_type     ctl;

   cell_down_type    down_chain [WINDOW_MAX+1];
   cell_up_type      up_chain   [WINDOW_MAX+1];
   sample_type       cell_value [WINDOW_MAX];

   // Effective window length: zero acts as one, large values saturate
   always_comb begin
      if (wsize_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (int'(wsize_ff) > WINDOW_MAX) begin
         k_eff = CNT_W'(WINDOW_MAX);
      end else begin
         k_eff = CNT_W'(wsize_ff);
      end
   end

   assign full     = (fill_ff == k_eff);
   assign n_kept   = full ? (k_eff - CNT_W'(1)) : fill_ff;
   assign mid      = IDX_W'((k_eff - CNT_W'(1)) >> 1);
   assign wr_addr  = full ? oldest_ff : fill_ff[IDX_W-1:0];

   // A pending window size write has priority over a sample
   assign req_chan.ready = (state_ff == S_IDLE) && !csr_chan.valid;
   assign csr_chan.ready = (state_ff == S_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_take = csr_chan.valid && csr_chan.ready;
   assign load_out = (state_ff == S_RES) && res_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.median = median_ff;

   // Chain control
   assign ctl = '{step: (state_ff == S_UPD), remove: full, key: key_ff, old: old_ff};

   // Sequencer and window bookkeeping
   always_comb begin
      state_in     = state_ff;
      wsize_in     = wsize_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (csr_take) begin
               wsize_in  = csr_chan.window_size;
               fill_in   = '0;
               oldest_in = '0;
            end else if (req_take) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (full) begin
               if ((CNT_W'(oldest_ff) + CNT_W'(1)) == k_eff) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + IDX_W'(1);
               end
               res_in = 1'b1;
            end else begin
               fill_in   = fill_ff + CNT_W'(1);
               oldest_in = '0;
               res_in    = ((fill_ff + CNT_W'(1)) == k_eff);
            end
            state_in = S_RES;
         end
         S_RES: begin
            if (!res_ff) begin
               state_in = S_IDLE;
            end else if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wsize_ff     <= cfg_type'(1);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         res_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample capture and arrival ring: read the leaving sample, write the new one
   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff <= req_chan.sample;
      end
      old_ff <= ring_mem[oldest_ff];
      if (state_ff == S_UPD) begin
         ring_mem[wr_addr] <= key_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         median_ff <= cell_value[mid];
      end
   end

   // Sorted chain
   assign down_chain[WINDOW_MAX] = '{value: '0, gt_key: 1'b0, eq_old: 1'b0};
   assign up_chain[0]            = '{rval: '0, gap: 1'b0};

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (CNT_W'(i) < fill_ff),
         .kept       (CNT_W'(i) < n_kept),
         .from_above (down_chain[i+1]),
         .to_below   (down_chain[i]),
         .from_below (up_chain[i]),
         .to_above   (up_chain[i+1]),
         .value      (cell_value[i])
      );
   end

endmodule

`default_nettype wire

// ===== dv/sliding_window_median_tb.sv =====
// Self-checking testbench for the sliding-window median filter.
`timescale 1ns / 100ps

import swm_pkg::*;

// Tracks the window contents and queues the medians the filter must produce
class median_scoreboard;
   sample_type  arrivals[WINDOW_MAX];
   sample_type  ordered[$];
   sample_type  medians_due[$];
   int unsigned span;
   int unsigned fill;
   int unsigned oldest;
   int unsigned failures;

   function new();
      failures = 0;
      restart(cfg_type'(1));
   endfunction

   // A window size write empties the window; zero acts as one, large sizes saturate
   function void restart(cfg_type size);
      span   = (size == 0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : size;
      fill   = 0;
      oldest = 0;
      ordered.delete();
   endfunction

   function int unsigned pending();
      return medians_due.size();
   endfunction

   // Accepted sample: update the window and queue a median once it is full
   function void note_sample(sample_type s);
      int unsigned pos;
      if (fill == span) begin
         // drop exactly one copy of the oldest value
         pos = 0;
         while (pos < ordered.size() && ordered[pos] != arrivals[oldest])
            pos++;
         ordered.delete(pos);
         arrivals[oldest] = s;
         oldest = (oldest + 1) % span;
      end else begin
         arrivals[fill] = s;
         fill++;
      end
      pos = 0;
      while (pos < ordered.size() && ordered[pos] <= s)
         pos++;
      ordered.insert(pos, s);
      if (fill == span)
         medians_due.insert(medians_due.size(), ordered[(span + 1) / 2 - 1]);
   endfunction

   // Accepted result: compare against the oldest queued median
   function void check_median(sample_type got);
      sample_type want;
      if (medians_due.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("%0t: median %0d with none expected", $realtime, got);
      end else begin
         want = medians_due.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("%0t: median mismatch, expected %0d got %0d",
                        $realtime, want, got);
         end
      end
   endfunction
endclass

module sliding_window_median_tb;

   localparam int          RANDOM_ITEMS = 1200;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int          SETTLE       = 8;
   localparam sample_type  MOST_NEG     = sample_type'(32'h8000_0000);
   localparam sample_type  MOST_POS     = sample_type'(32'h7FFF_FFFF);

   logic clock;
   logic reset;
   bit   steady;

   swm_req_if req_chan ();
   swm_rsp_if rsp_chan ();
   swm_csr_if csr_chan ();

   median_scoreboard sb = new();

   sliding_window_median i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Random idle decision, suppressed during the steady stretch
   function automatic bit takes_break();
      return !steady && ($urandom_range(99) < 37);
   endfunction

   // Result side: random backpressure, checked at the rising edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = !takes_break();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_median(rsp_chan.median);
   end

   // Watchdog: ends the run after too many cycles with no item accepted
   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("sliding_window_median_tb NOT OK");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input sample_type s);
      while (takes_break()) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid  = 1'b1;
      req_chan.sample = s;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(s);
      @(negedge clock);
   endtask

   // Hold the sender until every queued median has come out
   task automatic drain();
      req_chan.valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   // Window size write while idle; a filling item may still be in flight
   task automatic write_window(input cfg_type size);
      drain();
      repeat (SETTLE) @(negedge clock);
      while (takes_break())
         @(negedge clock);
      csr_chan.valid       = 1'b1;
      csr_chan.window_size = size;
      do @(posedge clock); while (!csr_chan.ready);
      sb.restart(size);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // style 0: narrow range with many duplicates, 1: full range, 2: extremes
   function automatic sample_type random_sample(input int style);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         style = $urandom_range(2);
      case (style)
         0: return sample_type'($signed($urandom_range(8)) - 4);
         1: return sample_type'($urandom);
         default: begin
            case ($urandom_range(6))
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return sample_type'(0);
               3: return sample_type'(-1);
               4: return MOST_NEG + 1;
               5: return MOST_POS - 1;
               default: return sample_type'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic cfg_type pick_window_size();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return cfg_type'($urandom_range(1, 8));
         6, 7: return cfg_type'($urandom_range(9, WINDOW_MAX));
         8: return cfg_type'($urandom_range(WINDOW_MAX + 1, 127));
         default: return cfg_type'(0);
      endcase
   endfunction

   // Stimulus
   initial begin
      cfg_type     opening_sizes[5];
      cfg_type     size;
      int unsigned sent;
      int unsigned phase;
      int unsigned phase_len;
      int unsigned pause_at;
      int unsigned i;
      int          style;

      opening_sizes = '{cfg_type'(64), cfg_type'(127), cfg_type'(65),
                        cfg_type'(1), cfg_type'(0)};
      steady               = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.sample      = '0;
      csr_chan.valid       = 1'b0;
      csr_chan.window_size = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Default window of one: every sample is its own median
      send_sample(MOST_NEG);
      send_sample(MOST_POS);
      send_sample(sample_type'(0));
      send_sample(sample_type'(-1));

      // Zero window size acts as one
      write_window(cfg_type'(0));
      send_sample(sample_type'(17));
      send_sample(MOST_NEG);

      // Window of three: filling, duplicates, eviction of one duplicate copy
      write_window(cfg_type'(3));
      send_sample(MOST_NEG);
      send_sample(MOST_POS);
      send_sample(sample_type'(-1));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(5));
      send_sample(MOST_NEG);

      // Even window: lower median
      write_window(cfg_type'(2));
      send_sample(MOST_POS);
      send_sample(MOST_NEG);
      send_sample(sample_type'(7));
      send_sample(sample_type'(7));

      // Random phases, each with its own window size and a mid-phase drain
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         size = (phase < 5) ? opening_sizes[phase] : pick_window_size();
         write_window(size);
         phase_len = sb.span + $urandom_range(8, 48);
         pause_at  = $urandom_range(phase_len - 1);
         style     = $urandom_range(2);
         for (i = 0; i < phase_len; i++) begin
            steady = (sent >= 400) && (sent < 600);
            if (i == pause_at)
               drain();
            send_sample(random_sample(style));
            sent++;
         end
         phase++;
      end
      steady = 1'b0;

      drain();
      repeat (12) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("sliding_window_median_tb OK");
      else
         $display("sliding_window_median_tb NOT OK");
      $finish;
   end

endmodule
